>>> hdl/fhcv_pkg.sv
// shared types, constants and ones-complement helpers for the frame header checksum validator
// no dependencies
`default_nettype none

package fhcv_pkg;

    localparam int unsigned POS_W = 6;

    localparam logic [POS_W-1:0] POS_SAT        = 6'd42;
    localparam logic [POS_W-1:0] POS_TYPE_HI    = 6'd12;
    localparam logic [POS_W-1:0] POS_TYPE_LO    = 6'd13;
    localparam logic [POS_W-1:0] POS_IP_START   = 6'd14;
    localparam logic [POS_W-1:0] POS_PROTOCOL   = 6'd23;
    localparam logic [POS_W-1:0] POS_IP_CSUM    = 6'd25;
    localparam logic [POS_W-1:0] POS_MSG_START  = 6'd34;
    localparam logic [POS_W-1:0] POS_MSG_CSUM   = 6'd37;
    localparam logic [POS_W-1:0] LEN_MIN_ICMP   = 6'd38;
    localparam logic [POS_W-1:0] LEN_MIN_ARP    = 6'd42;

    localparam logic [15:0] FRAME_TYPE_IPV4 = 16'h0800;
    localparam logic [15:0] FRAME_TYPE_ARP  = 16'h0806;
    localparam logic [7:0]  PROTO_ICMP      = 8'd1;
    localparam logic [15:0] CSUM_ALL_ONES   = 16'hffff;

    // one byte handed from the input register to the frame tracker
    typedef struct packed {
        logic       step;
        logic       last;
        logic [7:0] data_byte;
    } fhcv_step_t;

    function automatic logic [15:0] oc_add(input logic [15:0] s, input logic [15:0] w);
        logic [16:0] t;
        t = {1'b0, s} + {1'b0, w};
        return t[15:0] + {15'd0, t[16]};
    endfunction

    function automatic logic [15:0] oc_final(input logic [15:0] s);
        logic [15:0] r;
        r = ~s;
        return (r == 16'd0) ? CSUM_ALL_ONES : r;
    endfunction

endpackage

`default_nettype wire

>>> hdl/frame_header_checksum_validator_unit.sv
// Frame header checksum validator, top level.
// Takes an Ethernet frame one byte per transaction on the s_ channel, s_last marking
// the final byte, and gives one m_frame_valid bit per frame on the m_ channel.
// ARP frames need 42 bytes; IPv4 frames need 34 bytes and a good header checksum,
// and ICMP inside IPv4 also needs 38 bytes and a good message checksum.
// Bytes pass an input register, then the frame tracker updates its running sums;
// on the final byte the verdict is loaded into the output register.
// m_valid is driven by the output register, which is loaded when the final byte advances.
// Throughput: one byte per cycle while s_ready is high;
// the next frame's bytes are taken while a result still waits on the m_ side.
// If the receiver stalls with a result pending and the next final byte reaches
// the input register, s_ready drops until the pending result is taken.
// Reset (aresetn low, synchronous) empties both registers and clears the frame
// state; the block takes bytes once aresetn is high again.
// depends on fhcv_pkg and fhcv_frame_tracker
`default_nettype none

module frame_header_checksum_validator_unit (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_data_byte,
    input  wire logic       s_last,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic            m_frame_valid
);

    logic       in_valid_reg;
    logic       in_last_reg;
    logic [7:0] in_byte_reg;
    logic       m_valid_reg;
    logic       m_frame_valid_reg;
    logic       advance;
    logic       verdict;
    fhcv_pkg::fhcv_step_t step;

    // a final byte may only move on when the output register is free
    assign advance = in_valid_reg && !(in_last_reg && m_valid_reg && !m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        step.step      = advance;
        step.last      = in_last_reg;
        step.data_byte = in_byte_reg;
    end

    fhcv_frame_tracker u_tracker (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_in (step),
        .verdict (verdict)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_data_byte;
            in_last_reg <= s_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && in_last_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_last_reg) begin
            m_frame_valid_reg <= verdict;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_frame_valid = m_frame_valid_reg;

`ifndef SYNTH
    // a fresh result only follows a final byte leaving the input register
    a_result_from_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid_reg || m_ready) ##1 m_valid_reg |-> $past(advance && in_last_reg))
        else $error("result produced without a final byte");

    // backpressure only comes from a pending final byte behind a stalled result
    a_ready_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && in_last_reg && m_valid_reg && !m_ready))
        else $error("input stalled without cause");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid_reg)
        else $error("result present after reset");
`endif

endmodule

`default_nettype wire

>>> hdl/fhcv_frame_tracker.sv
// per-frame state: byte position, word pairing, running header and message sums
// depends on fhcv_pkg
`default_nettype none

module fhcv_frame_tracker (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire fhcv_pkg::fhcv_step_t step_in,
    output logic                   verdict
);

    logic [fhcv_pkg::POS_W-1:0] pos_reg, pos_next;
    logic        odd_reg, odd_next;
    logic [7:0]  high_reg, high_next;
    logic [15:0] type_reg, type_next;
    logic [7:0]  proto_reg, proto_next;
    logic [15:0] hsum_reg, hsum_next;
    logic [15:0] hstored_reg, hstored_next;
    logic [15:0] msum_reg, msum_next;
    logic [15:0] mstored_reg, mstored_next;
    logic [15:0] word;
    logic        hdr_ok;
    logic        msg_ok;

    always_comb begin
        word         = {high_reg, step_in.data_byte};
        pos_next     = pos_reg;
        odd_next     = odd_reg;
        high_next    = high_reg;
        type_next    = type_reg;
        proto_next   = proto_reg;
        hsum_next    = hsum_reg;
        hstored_next = hstored_reg;
        msum_next    = msum_reg;
        mstored_next = mstored_reg;

        if (pos_reg == fhcv_pkg::POS_TYPE_HI) begin
            type_next[15:8] = step_in.data_byte;
        end else if (pos_reg == fhcv_pkg::POS_TYPE_LO) begin
            type_next[7:0] = step_in.data_byte;
        end
        if (pos_reg == fhcv_pkg::POS_PROTOCOL) begin
            proto_next = step_in.data_byte;
        end

        if (pos_reg >= fhcv_pkg::POS_IP_START && pos_reg < fhcv_pkg::POS_MSG_START) begin
            if (odd_reg) begin
                if (pos_reg == fhcv_pkg::POS_IP_CSUM) begin
                    hstored_next = word;
                end else begin
                    hsum_next = fhcv_pkg::oc_add(hsum_reg, word);
                end
            end
        end else if (pos_reg >= fhcv_pkg::POS_MSG_START) begin
            if (odd_reg) begin
                if (pos_reg == fhcv_pkg::POS_MSG_CSUM) begin
                    mstored_next = word;
                end else begin
                    msum_next = fhcv_pkg::oc_add(msum_reg, word);
                end
            end else if (step_in.last) begin
                // odd length: final byte padded with a zero low byte
                msum_next = fhcv_pkg::oc_add(msum_reg, {step_in.data_byte, 8'd0});
            end
        end

        if (!odd_reg) begin
            high_next = step_in.data_byte;
        end
        odd_next = ~odd_reg;
        if (pos_reg < fhcv_pkg::POS_SAT) begin
            pos_next = pos_reg + 1'b1;
        end
    end

    // verdict on the updated state, only meaningful on the last byte
    always_comb begin
        hdr_ok  = (fhcv_pkg::oc_final(hsum_next) == hstored_next);
        msg_ok  = (fhcv_pkg::oc_final(msum_next) == mstored_next);
        verdict = 1'b0;
        if (pos_next >= fhcv_pkg::POS_IP_START) begin
            if (type_next == fhcv_pkg::FRAME_TYPE_ARP) begin
                verdict = (pos_next >= fhcv_pkg::LEN_MIN_ARP);
            end else if (type_next == fhcv_pkg::FRAME_TYPE_IPV4) begin
                if (pos_next >= fhcv_pkg::POS_MSG_START && hdr_ok) begin
                    if (proto_next == fhcv_pkg::PROTO_ICMP) begin
                        verdict = (pos_next >= fhcv_pkg::LEN_MIN_ICMP) && msg_ok;
                    end else begin
                        verdict = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (step_in.step && step_in.last)) begin
            pos_reg     <= '0;
            odd_reg     <= 1'b0;
            high_reg    <= '0;
            type_reg    <= '0;
            proto_reg   <= '0;
            hsum_reg    <= '0;
            hstored_reg <= '0;
            msum_reg    <= '0;
            mstored_reg <= '0;
        end else if (step_in.step) begin
            pos_reg     <= pos_next;
            odd_reg     <= odd_next;
            high_reg    <= high_next;
            type_reg    <= type_next;
            proto_reg   <= proto_next;
            hsum_reg    <= hsum_next;
            hstored_reg <= hstored_next;
            msum_reg    <= msum_next;
            mstored_reg <= mstored_next;
        end
    end

endmodule

`default_nettype wire
